[hdl/itspc_pkg.sv]
// Package for the ISO 8601 timestamp precision checker.
// Holds parse phases, precision codes, the parser state and result structs
// and the month length table. No dependencies.
`default_nettype none

package itspc_pkg;

  // Parse phase: position in the expected timestamp grammar
  typedef enum logic [4:0] {
    PH_CENT0      = 5'd0,
    PH_CENT1      = 5'd1,
    PH_YEAR0      = 5'd2,
    PH_YEAR1      = 5'd3,
    PH_DASH1      = 5'd4,
    PH_MON0       = 5'd5,
    PH_MON1       = 5'd6,
    PH_DASH2      = 5'd7,
    PH_DAY0       = 5'd8,
    PH_DAY1       = 5'd9,
    PH_T          = 5'd10,
    PH_HR0        = 5'd11,
    PH_HR1        = 5'd12,
    PH_COLON1     = 5'd13,
    PH_MIN0       = 5'd14,
    PH_MIN1       = 5'd15,
    PH_AFTER_MIN  = 5'd16,
    PH_SEC0       = 5'd17,
    PH_SEC1       = 5'd18,
    PH_AFTER_SEC  = 5'd19,
    PH_FRAC_FIRST = 5'd20,
    PH_FRAC       = 5'd21,
    PH_ZH0        = 5'd22,
    PH_ZH1        = 5'd23,
    PH_ZCOLON     = 5'd24,
    PH_ZM0        = 5'd25,
    PH_ZM1        = 5'd26,
    PH_DONE       = 5'd27
  } phase_t;

  // Precision codes
  localparam logic [2:0] PREC_YEAR   = 3'd0;
  localparam logic [2:0] PREC_MONTH  = 3'd1;
  localparam logic [2:0] PREC_DAY    = 3'd2;
  localparam logic [2:0] PREC_MINUTE = 3'd3;
  localparam logic [2:0] PREC_SECOND = 3'd4;
  localparam logic [2:0] PREC_SUBSEC = 3'd5;

  // Field limits
  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINSEC_MAX = 7'd59;
  localparam logic [6:0] FEB_LEAP   = 7'd29;
  localparam logic [6:0] MONTH_FEB  = 7'd2;

  // ASCII codes used by the grammar
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // Parser state carried from byte to byte
  typedef struct packed {
    phase_t     phase;
    logic       failed;
    logic [6:0] cent;
    logic [6:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] pair;
    logic [2:0] level;
  } parse_st_t;

  // Verdict on the final byte
  typedef struct packed {
    logic       ok;
    logic [2:0] prec;
  } verdict_t;

  // Days in a non-leap year month (1..12)
  function automatic logic [6:0] month_days(input logic [6:0] m);
    logic [6:0] r;
    unique case (m)
      7'd2:                      r = 7'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   r = 7'd30;
      default:                   r = 7'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/itspc_step.sv]
// One-byte parser step for the timestamp checker: next state and verdict.
// Pure combinational logic; depends on itspc_pkg.
`default_nettype none

module itspc_step (
  input  wire itspc_pkg::parse_st_t cur,
  input  wire logic [7:0]           character,
  input  wire logic                 final_byte,
  output itspc_pkg::parse_st_t      nxt,
  output itspc_pkg::verdict_t       verdict
);

  itspc_pkg::parse_st_t mid;
  logic        dig;
  logic [3:0]  d;
  logic [10:0] cent_acc;
  logic [10:0] year_acc;
  logic [10:0] pair_acc;
  logic [10:0] mon_acc;
  logic [10:0] day_acc;
  logic [6:0]  pair_new;
  logic [6:0]  day_new;
  logic [6:0]  mon_new;
  logic        leap;
  logic [6:0]  day_limit;
  logic        fail;
  logic        step_ph;

  // Digit decode and times-ten accumulators
  assign dig      = (character >= itspc_pkg::CH_ZERO) && (character <= itspc_pkg::CH_NINE);
  assign d        = dig ? character[3:0] : 4'd0;
  assign cent_acc = {cur.cent, 3'b000} + {3'b000, cur.cent, 1'b0} + {7'd0, d};
  assign year_acc = {cur.year, 3'b000} + {3'b000, cur.year, 1'b0} + {7'd0, d};
  assign pair_acc = {cur.pair, 3'b000} + {3'b000, cur.pair, 1'b0} + {7'd0, d};
  assign mon_acc  = {cur.month, 3'b000} + {3'b000, cur.month, 1'b0} + {7'd0, d};
  assign day_acc  = {cur.day, 3'b000} + {3'b000, cur.day, 1'b0} + {7'd0, d};
  assign pair_new = pair_acc[6:0];
  assign mon_new  = mon_acc[6:0];
  assign day_new  = day_acc[6:0];

  // Gregorian leap year and month length
  assign leap = (cur.year[1:0] == 2'd0) &&
                ((cur.year != 7'd0) || (cur.cent[1:0] == 2'd0));
  assign day_limit = ((cur.month == itspc_pkg::MONTH_FEB) && leap) ?
                     itspc_pkg::FEB_LEAP : itspc_pkg::month_days(cur.month);

  // Consume one byte
  always_comb begin
    mid     = cur;
    fail    = 1'b0;
    step_ph = 1'b1;
    if (!cur.failed) begin
      unique case (cur.phase)
        itspc_pkg::PH_CENT0, itspc_pkg::PH_CENT1: begin
          if (!dig) fail = 1'b1;
          else mid.cent = cent_acc[6:0];
        end
        itspc_pkg::PH_YEAR0, itspc_pkg::PH_YEAR1: begin
          if (!dig) fail = 1'b1;
          else mid.year = year_acc[6:0];
        end
        itspc_pkg::PH_DASH1, itspc_pkg::PH_DASH2: begin
          if (character != itspc_pkg::CH_DASH) fail = 1'b1;
        end
        itspc_pkg::PH_MON0: begin
          if (!dig) fail = 1'b1;
          else mid.month = {3'd0, d};
        end
        itspc_pkg::PH_MON1: begin
          if (!dig) fail = 1'b1;
          else begin
            mid.month = mon_new;
            if ((mon_new == 7'd0) || (mon_new > itspc_pkg::MONTH_MAX)) fail = 1'b1;
          end
        end
        itspc_pkg::PH_DAY0: begin
          if (!dig) fail = 1'b1;
          else mid.day = {3'd0, d};
        end
        itspc_pkg::PH_DAY1: begin
          if (!dig) fail = 1'b1;
          else begin
            mid.day = day_new;
            if ((cur.month == 7'd0) || (cur.month > itspc_pkg::MONTH_MAX) ||
                (day_new == 7'd0) || (day_new > day_limit)) fail = 1'b1;
          end
        end
        itspc_pkg::PH_T: begin
          if (character != itspc_pkg::CH_T) fail = 1'b1;
        end
        itspc_pkg::PH_HR0, itspc_pkg::PH_MIN0, itspc_pkg::PH_SEC0,
        itspc_pkg::PH_ZH0, itspc_pkg::PH_ZM0: begin
          if (!dig) fail = 1'b1;
          else mid.pair = {3'd0, d};
        end
        itspc_pkg::PH_HR1, itspc_pkg::PH_ZH1: begin
          if (!dig) fail = 1'b1;
          else begin
            mid.pair = pair_new;
            if (pair_new > itspc_pkg::HOUR_MAX) fail = 1'b1;
          end
        end
        itspc_pkg::PH_MIN1, itspc_pkg::PH_SEC1, itspc_pkg::PH_ZM1: begin
          if (!dig) fail = 1'b1;
          else begin
            mid.pair = pair_new;
            if (pair_new > itspc_pkg::MINSEC_MAX) fail = 1'b1;
            else if (cur.phase == itspc_pkg::PH_MIN1) mid.level = itspc_pkg::PREC_MINUTE;
            else if (cur.phase == itspc_pkg::PH_SEC1) mid.level = itspc_pkg::PREC_SECOND;
          end
        end
        itspc_pkg::PH_COLON1, itspc_pkg::PH_ZCOLON: begin
          if (character != itspc_pkg::CH_COLON) fail = 1'b1;
        end
        // Optional seconds, fraction or zone; zone start jumps ahead
        itspc_pkg::PH_AFTER_MIN, itspc_pkg::PH_AFTER_SEC, itspc_pkg::PH_FRAC: begin
          if ((cur.phase == itspc_pkg::PH_AFTER_MIN) && (character == itspc_pkg::CH_COLON)) begin
            step_ph = 1'b1;
          end else if ((cur.phase == itspc_pkg::PH_AFTER_SEC) &&
                       (character == itspc_pkg::CH_DOT)) begin
            step_ph = 1'b1;
          end else if ((cur.phase == itspc_pkg::PH_FRAC) && dig) begin
            step_ph = 1'b0;
          end else begin
            step_ph = 1'b0;
            if (character == itspc_pkg::CH_Z) mid.phase = itspc_pkg::PH_DONE;
            else if ((character == itspc_pkg::CH_PLUS) || (character == itspc_pkg::CH_DASH))
              mid.phase = itspc_pkg::PH_ZH0;
            else fail = 1'b1;
          end
        end
        itspc_pkg::PH_FRAC_FIRST: begin
          step_ph = 1'b0;
          if (!dig) fail = 1'b1;
          else begin
            mid.level = itspc_pkg::PREC_SUBSEC;
            mid.phase = itspc_pkg::PH_FRAC;
          end
        end
        // Anything after a complete zone is an error
        default: begin
          fail = 1'b1;
        end
      endcase
      if (fail) mid.failed = 1'b1;
      else if (step_ph) mid.phase = itspc_pkg::phase_t'(5'(cur.phase) + 5'd1);
    end
  end

  // Verdict and clear at end of string
  always_comb begin
    verdict.ok   = 1'b0;
    verdict.prec = itspc_pkg::PREC_YEAR;
    if (!mid.failed) begin
      unique case (mid.phase)
        itspc_pkg::PH_DASH1: begin
          verdict.ok = 1'b1; verdict.prec = itspc_pkg::PREC_YEAR;
        end
        itspc_pkg::PH_DASH2: begin
          verdict.ok = 1'b1; verdict.prec = itspc_pkg::PREC_MONTH;
        end
        itspc_pkg::PH_T: begin
          verdict.ok = 1'b1; verdict.prec = itspc_pkg::PREC_DAY;
        end
        itspc_pkg::PH_AFTER_MIN, itspc_pkg::PH_AFTER_SEC, itspc_pkg::PH_FRAC,
        itspc_pkg::PH_DONE: begin
          verdict.ok = 1'b1; verdict.prec = mid.level;
        end
        default: begin
          verdict.ok = 1'b0;
        end
      endcase
    end
    nxt = mid;
    if (final_byte) nxt = '0;
  end

endmodule

`default_nettype wire

[hdl/iso8601_timestamp_precision_check_core.sv]
// A final byte passes the input register, then the result register, before its result is valid.
// Throughput: one byte per cycle; a non-final byte never waits on the output.
// Only a final byte holds in the input register while the result register is full.
// Reset (rst, synchronous, active high) empties both registers and returns the
// parser to the start of a string with all field values cleared.
`default_nettype none

module iso8601_timestamp_precision_check_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] character,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            valid_res,
  output logic [2:0]      precision
);

  logic                 in_vld_q;
  logic [7:0]           char_q;
  logic                 fin_q;
  itspc_pkg::parse_st_t st;
  itspc_pkg::parse_st_t st_next;
  itspc_pkg::verdict_t  verdict;
  logic                 out_free;
  logic                 adv;

  // Handshake control
  assign out_free = !out_valid || !out_stall;
  assign adv      = in_vld_q && (!fin_q || out_free);
  assign in_stall = in_vld_q && !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall) begin
      in_vld_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_q <= character;
      fin_q  <= final_byte;
    end
  end

  // Parser step
  itspc_step u_step (
    .cur        (st),
    .character  (char_q),
    .final_byte (fin_q),
    .nxt        (st_next),
    .verdict    (verdict)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && fin_q) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_q) begin
      valid_res <= verdict.ok;
      precision <= verdict.prec;
    end
  end

  // Checks
  a_invalid_prec_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> precision == itspc_pkg::PREC_YEAR)
    else $error("invalid result with nonzero precision");

  a_prec_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> precision <= itspc_pkg::PREC_SUBSEC)
    else $error("precision code out of range");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    adv && fin_q |=> st.phase == itspc_pkg::PH_CENT0 && !st.failed)
    else $error("parser not cleared after final byte");

  a_stall_only_final: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_vld_q && fin_q && out_valid)
    else $error("input stalled without a pending final byte");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    adv && fin_q |=> out_valid)
    else $error("final byte produced no result");

endmodule

`default_nettype wire

[verif/iso8601_timestamp_precision_check_core_test.sv]
// Self-checking testbench for iso8601_timestamp_precision_check_core.
// Streams timestamp text byte by byte and checks each verdict against an
// in-bench parser model. Depends on itspc_pkg and the core RTL.
`default_nettype none

module iso8601_timestamp_precision_check_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES   = 1800;
  localparam int HOLD_CYCLES    = 120;
  localparam int HOLD_AFTER     = 60;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_byte_t;

  // DUT signals
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] character = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       valid_res;
  logic [2:0] precision;

  // Stimulus and scoreboard storage
  text_byte_t          bytes_to_send[$];
  logic [7:0]          text_buf[$];
  itspc_pkg::verdict_t verdicts_due[$];
  text_byte_t          next_byte;
  itspc_pkg::verdict_t due_verdict;
  itspc_pkg::verdict_t new_verdict;
  int         total_bytes = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;
  int         hold_left = 0;
  bit         pressure_done = 1'b0;
  int         quiet_cycles = 0;

  // Parser model state
  itspc_pkg::phase_t p_phase = itspc_pkg::PH_CENT0;
  logic       p_failed = 1'b0;
  logic [6:0] p_cent = '0;
  logic [6:0] p_year = '0;
  logic [6:0] p_month = '0;
  logic [6:0] p_day = '0;
  logic [6:0] p_pair = '0;
  logic [2:0] p_level = '0;

  // Non-leap month lengths, index 0 unused
  int days_per_month[13] = '{31, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  iso8601_timestamp_precision_check_core u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .character  (character),
    .final_byte (final_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .valid_res  (valid_res),
    .precision  (precision)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------

  // Gregorian leap rule on the two-digit century / year split
  function automatic bit year_is_leap();
    if (p_year % 4 != 0) return 1'b0;
    if (p_year != 0) return 1'b1;
    return (p_cent % 4) == 0;
  endfunction

  function automatic bit date_fits();
    int lim;
    if (p_month < 1 || p_month > itspc_pkg::MONTH_MAX || p_day == 0) return 1'b0;
    lim = (p_month == itspc_pkg::MONTH_FEB && year_is_leap()) ?
          itspc_pkg::FEB_LEAP : days_per_month[p_month];
    return p_day <= lim;
  endfunction

  // Zone may open here: Z closes the string, sign starts an offset
  function automatic bit zone_lead(input logic [7:0] c);
    if (c == itspc_pkg::CH_Z) begin
      p_phase = itspc_pkg::PH_DONE;
      return 1'b1;
    end
    if (c == itspc_pkg::CH_PLUS || c == itspc_pkg::CH_DASH) begin
      p_phase = itspc_pkg::PH_ZH0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Consume one byte; returns 1 with the verdict when the byte ends a string
  function automatic bit step_timestamp(input logic [7:0] c, input logic fin,
                                        output itspc_pkg::verdict_t vd);
    logic dig;
    logic bad;
    logic adv;
    int   d;
    dig = (c >= itspc_pkg::CH_ZERO) && (c <= itspc_pkg::CH_NINE);
    d = dig ? int'(c - itspc_pkg::CH_ZERO) : 0;
    vd = '0;
    if (!p_failed) begin
      bad = 1'b0;
      adv = 1'b1;
      case (p_phase)
        itspc_pkg::PH_CENT0, itspc_pkg::PH_CENT1: begin
          bad = !dig;
          if (dig) p_cent = 7'(p_cent * 10 + d);
        end
        itspc_pkg::PH_YEAR0, itspc_pkg::PH_YEAR1: begin
          bad = !dig;
          if (dig) p_year = 7'(p_year * 10 + d);
        end
        itspc_pkg::PH_DASH1, itspc_pkg::PH_DASH2: bad = (c != itspc_pkg::CH_DASH);
        itspc_pkg::PH_MON0: begin
          bad = !dig;
          if (dig) p_month = 7'(d);
        end
        itspc_pkg::PH_MON1: begin
          bad = !dig;
          if (dig) begin
            p_month = 7'(p_month * 10 + d);
            bad = (p_month < 1) || (p_month > itspc_pkg::MONTH_MAX);
          end
        end
        itspc_pkg::PH_DAY0: begin
          bad = !dig;
          if (dig) p_day = 7'(d);
        end
        itspc_pkg::PH_DAY1: begin
          bad = !dig;
          if (dig) begin
            p_day = 7'(p_day * 10 + d);
            bad = !date_fits();
          end
        end
        itspc_pkg::PH_T: bad = (c != itspc_pkg::CH_T);
        itspc_pkg::PH_HR0, itspc_pkg::PH_MIN0, itspc_pkg::PH_SEC0,
        itspc_pkg::PH_ZH0, itspc_pkg::PH_ZM0: begin
          bad = !dig;
          if (dig) p_pair = 7'(d);
        end
        itspc_pkg::PH_HR1, itspc_pkg::PH_ZH1: begin
          bad = !dig;
          if (dig) begin
            p_pair = 7'(p_pair * 10 + d);
            bad = p_pair > itspc_pkg::HOUR_MAX;
          end
        end
        itspc_pkg::PH_MIN1, itspc_pkg::PH_SEC1, itspc_pkg::PH_ZM1: begin
          bad = !dig;
          if (dig) begin
            p_pair = 7'(p_pair * 10 + d);
            bad = p_pair > itspc_pkg::MINSEC_MAX;
            if (!bad && p_phase == itspc_pkg::PH_MIN1) p_level = itspc_pkg::PREC_MINUTE;
            if (!bad && p_phase == itspc_pkg::PH_SEC1) p_level = itspc_pkg::PREC_SECOND;
          end
        end
        itspc_pkg::PH_COLON1, itspc_pkg::PH_ZCOLON: bad = (c != itspc_pkg::CH_COLON);
        itspc_pkg::PH_AFTER_MIN: begin
          if (c != itspc_pkg::CH_COLON) begin
            adv = 1'b0;
            bad = !zone_lead(c);
          end
        end
        itspc_pkg::PH_AFTER_SEC: begin
          if (c != itspc_pkg::CH_DOT) begin
            adv = 1'b0;
            bad = !zone_lead(c);
          end
        end
        itspc_pkg::PH_FRAC_FIRST: begin
          adv = 1'b0;
          bad = !dig;
          if (dig) begin
            p_level = itspc_pkg::PREC_SUBSEC;
            p_phase = itspc_pkg::PH_FRAC;
          end
        end
        itspc_pkg::PH_FRAC: begin
          adv = 1'b0;
          if (!dig) bad = !zone_lead(c);
        end
        // anything after a closed zone
        default: bad = 1'b1;
      endcase
      if (bad) p_failed = 1'b1;
      else if (adv) p_phase = itspc_pkg::phase_t'(p_phase + 5'd1);
    end
    if (!fin) return 1'b0;

    // Verdict: only phases that end a legal form are accepted
    if (!p_failed) begin
      case (p_phase)
        itspc_pkg::PH_DASH1: begin vd.ok = 1'b1; vd.prec = itspc_pkg::PREC_YEAR; end
        itspc_pkg::PH_DASH2: begin vd.ok = 1'b1; vd.prec = itspc_pkg::PREC_MONTH; end
        itspc_pkg::PH_T:     begin vd.ok = 1'b1; vd.prec = itspc_pkg::PREC_DAY; end
        itspc_pkg::PH_AFTER_MIN, itspc_pkg::PH_AFTER_SEC, itspc_pkg::PH_FRAC,
        itspc_pkg::PH_DONE: begin
          vd.ok = 1'b1;
          vd.prec = p_level;
        end
        default: vd = '0;
      endcase
    end
    p_phase = itspc_pkg::PH_CENT0;
    p_failed = 1'b0;
    p_cent = '0;
    p_year = '0;
    p_month = '0;
    p_day = '0;
    p_pair = '0;
    p_level = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic push_dec(input int v, input int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      text_buf.push_back(8'(itspc_pkg::CH_ZERO + (v / div) % 10));
      div /= 10;
    end
  endtask

  // Close the text in the buffer as one string, last byte flagged
  task automatic flush_text();
    foreach (text_buf[i]) bytes_to_send.push_back({text_buf[i], i == text_buf.size() - 1});
    text_buf.delete();
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'(itspc_pkg::CH_ZERO + $urandom_range(9));
      4:          return itspc_pkg::CH_DASH;
      5:          return itspc_pkg::CH_COLON;
      6:          return ($urandom_range(1) == 0) ? itspc_pkg::CH_PLUS : itspc_pkg::CH_DOT;
      7:          return ($urandom_range(1) == 0) ? itspc_pkg::CH_T : itspc_pkg::CH_Z;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly well-formed timestamp with random content, sometimes damaged
  task automatic gen_timestamp();
    int form;
    int mon;
    int day;
    int cut;
    form = $urandom_range(5);
    push_dec($urandom_range(99), 2);
    push_dec(($urandom_range(5) == 0) ? 0 : $urandom_range(99), 2);
    if (form >= 1) begin
      text_buf.push_back(itspc_pkg::CH_DASH);
      mon = ($urandom_range(7) == 0) ? $urandom_range(19) : $urandom_range(1, 12);
      if (form >= 2 && $urandom_range(5) == 0) mon = 2;
      push_dec(mon, 2);
    end
    if (form >= 2) begin
      text_buf.push_back(itspc_pkg::CH_DASH);
      if ($urandom_range(7) == 0 || mon < 1 || mon > 12) day = $urandom_range(39);
      else day = $urandom_range(1, days_per_month[mon] + (mon == 2));
      push_dec(day, 2);
    end
    if (form >= 3) begin
      text_buf.push_back(itspc_pkg::CH_T);
      push_dec(($urandom_range(7) == 0) ? $urandom_range(29) : $urandom_range(23), 2);
      text_buf.push_back(itspc_pkg::CH_COLON);
      push_dec(($urandom_range(7) == 0) ? $urandom_range(69) : $urandom_range(59), 2);
    end
    if (form >= 4) begin
      text_buf.push_back(itspc_pkg::CH_COLON);
      push_dec(($urandom_range(7) == 0) ? $urandom_range(69) : $urandom_range(59), 2);
    end
    if (form == 5) begin
      text_buf.push_back(itspc_pkg::CH_DOT);
      repeat ($urandom_range(1, 12))
        text_buf.push_back(8'(itspc_pkg::CH_ZERO + $urandom_range(9)));
    end
    if (form >= 3 && $urandom_range(2) != 0) begin
      if ($urandom_range(2) == 0) text_buf.push_back(itspc_pkg::CH_Z);
      else begin
        text_buf.push_back(($urandom_range(1) == 0) ? itspc_pkg::CH_PLUS : itspc_pkg::CH_DASH);
        push_dec(($urandom_range(7) == 0) ? $urandom_range(29) : $urandom_range(23), 2);
        text_buf.push_back(itspc_pkg::CH_COLON);
        push_dec(($urandom_range(7) == 0) ? $urandom_range(69) : $urandom_range(59), 2);
      end
    end
    // occasional damage: overwrite, truncate or extend
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(2))
        0: text_buf[$urandom_range(text_buf.size() - 1)] = pick_byte();
        1: begin
          cut = $urandom_range(1, text_buf.size());
          while (text_buf.size() > cut) void'(text_buf.pop_back());
        end
        default: text_buf.push_back(pick_byte());
      endcase
    end
    flush_text();
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 10)) text_buf.push_back(pick_byte());
    flush_text();
  endtask

  // ---------------------------------------------------------------------
  // Traffic shaping: four phases by progress through the stream
  // ---------------------------------------------------------------------

  function automatic int traffic_mode();
    int m;
    if (total_bytes == 0) return 0;
    m = bytes_taken * 4 / total_bytes;
    return (m > 3) ? 3 : m;
  endfunction

  function automatic int idle_pct(input int mode, input bit rcv_side);
    case (mode)
      1:       return rcv_side ? 0 : 83;
      2:       return rcv_side ? 83 : 0;
      3:       return 34;
      default: return 0;
    endcase
  endfunction

  // Sender: next byte only once the current one has been taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct(traffic_mode(), 1'b0)) begin
        next_byte = bytes_to_send.pop_front();
        in_valid <= 1'b1;
        character <= next_byte.ch;
        final_byte <= next_byte.fin;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus one long hold early on to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && bytes_taken >= HOLD_AFTER) begin
      pressure_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct(traffic_mode(), 1'b1));
    end
  end

  // Monitor: check results first, then record the byte taken this cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (verdicts_due.size() == 0) begin
          $error("unexpected transaction: valid_res %0b precision %0d", valid_res, precision);
          mismatches++;
        end else begin
          due_verdict = verdicts_due.pop_front();
          if (valid_res !== due_verdict.ok) begin
            $error("valid_res: expected %0b, actual %0b", due_verdict.ok, valid_res);
            mismatches++;
          end
          if (precision !== due_verdict.prec) begin
            $error("precision: expected %0d, actual %0d", due_verdict.prec, precision);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (step_timestamp(character, final_byte, new_verdict))
          verdicts_due.push_back(new_verdict);
        bytes_taken <= bytes_taken + 1;
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    // byte extremes
    text_buf.push_back(8'hFF);
    flush_text();
    add_str("2023");
    text_buf.push_back(8'h00);
    flush_text();
    // each precision, leap rules, limits, zones
    add_str("0000-02-29");                      flush_text();
    add_str("1900-02-29");                      flush_text();
    add_str("2023");                            flush_text();
    add_str("2023-12");                         flush_text();
    add_str("2023-00");                         flush_text();
    add_str("2023-04-31");                      flush_text();
    add_str("2023-06-15T23:59");                flush_text();
    add_str("2023-06-15T24:00");                flush_text();
    add_str("2023-06-15T12:60");                flush_text();
    add_str("2000-02-29T00:00:00");             flush_text();
    add_str("2023-06-15T12:34:59.0123456789Z"); flush_text();
    add_str("2023-06-15T12:34:56+23:59");       flush_text();
    add_str("2023-06-15T12:34-00:00");          flush_text();
    add_str("2023-06-15T12:34:56+24:00");       flush_text();
    // text after a closed zone, bare fraction, fraction after minutes
    add_str("2023-06-15T12:34Z0");              flush_text();
    add_str("2023-06-15T12:34:56.");            flush_text();
    add_str("2023-06-15T12:34.5");              flush_text();
    // early error then ignored bytes, and truncation
    add_str("20x3-06-15");                      flush_text();
    add_str("2023-");                           flush_text();

    // random part: mostly structured timestamps, some noise
    while (bytes_to_send.size() < RANDOM_BYTES) begin
      if ($urandom_range(3) == 0) gen_noise();
      else gen_timestamp();
    end
    total_bytes = bytes_to_send.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (bytes_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
